// ----- hw/rtl/igt_pkg.sv -----
package igt_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_SCAN_END,
        ST_ITER_RD,
        ST_ITER_ACC,
        ST_DIV,
        ST_FRAC,
        ST_DECIDE,
        ST_WIPE,
        ST_REPORT
    } igt_state_t;

    localparam logic       OP_ACCUM    = 1'b0;
    localparam logic       OP_CLASSIFY = 1'b1;
    localparam logic [7:0] WHITE_LEVEL = 8'd255;

endpackage

// ----- hw/rtl/iterative_global_threshold.sv -----
// Two-pass gray-level binarizer (isodata threshold). A pass-0 transaction (tuser op = 0) adds
// its pixel to a histogram held in one RAM of LEVELS bins, saturating at MAX_PIXELS; it is a
// read, then a write back, and gives no result unless it carries tlast. The transaction with
// tlast starts the threshold search: one scan of all levels finds the lowest and highest
// occupied levels, each iteration then sweeps the occupied range once, divides both sums
// with a shared bit-serial divider, one mean after the other, and then runs the rounding
// test, up to MAX_ITER iterations; a clearing pass over all bins follows before the report.
// After reset the same clearing pass runs before the first transaction is taken. Pass-1
// transactions (op = 1) are classified into the output register, and a new one is taken
// whenever that register is free.
module iterative_global_threshold
    import igt_pkg::*;
#(
    parameter int LEVELS     = 256,
    parameter int MAX_PIXELS = 1048575,
    parameter int MAX_ITER   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel[7:0]
    input  logic        s_axis_tuser,   // op[0]
    input  logic        s_axis_tlast,   // end_of_pass
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // binary_pixel[7:0], threshold_level[15:8]
    output logic [1:0]  m_axis_tuser    // is_threshold_report[0], converged[1]
);

    localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int NW = CW + 8;              // pixel count sum
    localparam int SW = CW + 16;             // level-weighted sum
    localparam int IW = $clog2(MAX_ITER + 1);
    localparam logic [CW-1:0] CMAX = CW'(MAX_PIXELS);
    localparam logic [AW-1:0] TOP = AW'(LEVELS - 1);

    igt_state_t state_reg, state_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [CW-1:0] ram_wdata, ram_rdata;

    igt_ram #(.WIDTH(CW), .DEPTH(LEVELS)) u_hist (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    logic          in_op;
    logic [7:0]    in_pix;
    logic [AW-1:0] in_bin;
    assign in_op  = s_axis_tuser;
    assign in_pix = s_axis_tdata;
    assign in_bin = (32'(in_pix) >= 32'(LEVELS)) ? TOP : in_pix[AW-1:0];

    logic [AW-1:0] addr_reg, addr_next;   // sweep address
    logic [AW-1:0] bin_reg;
    logic          last_reg;
    logic [AW-1:0] lo_reg, hi_reg;
    logic          found_reg;
    logic [7:0]    t_reg, thr_reg, tn_reg;
    logic          conv_reg;
    logic [IW-1:0] it_reg;
    logic          rd_v_reg;
    logic [AW-1:0] rd_g_reg;
    logic [NW-1:0] n1_reg, n2_reg;
    logic [SW-1:0] s1_reg, s2_reg;
    // shared restoring divider
    logic          div_sel_reg;           // 0: s1/n1, 1: s2/n2
    logic [SW-1:0] dq_reg;
    logic [NW:0]   drem_reg;
    logic [5:0]    dcnt_reg;
    logic [7:0]    q1_reg, q2_reg;
    logic [NW-1:0] r1_reg, r2_reg;
    logic [2*NW-1:0] pa_reg, pb_reg;
    logic          ov_v_reg;
    logic [15:0]   ov_data_reg;
    logic [1:0]    ov_user_reg;

    // fold in the top bin, whose read data arrives at the end of the scan
    logic          scan_hit, found_eff;
    logic [AW-1:0] lo_eff, hi_eff;
    assign scan_hit  = rd_v_reg && (ram_rdata != '0);
    assign found_eff = found_reg || scan_hit;
    assign lo_eff    = found_reg ? lo_reg : rd_g_reg;
    assign hi_eff    = scan_hit ? rd_g_reg : hi_reg;

    logic out_free;
    assign out_free = !ov_v_reg || m_axis_tready;

    always_comb
    begin
        s_axis_tready = 1'b0;
        if (state_reg == ST_IDLE)
        begin
            s_axis_tready = out_free;
        end
    end

    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    logic [NW:0] dtrial;
    logic [NW-1:0] dden;
    assign dden   = div_sel_reg ? n2_reg : n1_reg;
    assign dtrial = {drem_reg[NW-1:0], dq_reg[SW-1]} - {1'b0, dden};

    logic [8:0] qsum;
    assign qsum = 9'(q1_reg) + 9'(q2_reg);

    logic [7:0] tn_calc;
    always_comb
    begin
        tn_calc = qsum[8:1];
        if (qsum[0] && (pa_reg >= pb_reg))
        begin
            tn_calc = qsum[8:1] + 8'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                addr_next = addr_reg + AW'(1);
                if (addr_reg == TOP)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (acc && in_op == OP_ACCUM)
                begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW:
            begin
                addr_next  = '0;
                state_next = last_reg ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                addr_next = addr_reg + AW'(1);
                if (addr_reg == TOP)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                addr_next = lo_eff;
                if (!found_eff || lo_eff == hi_eff)
                begin
                    addr_next  = '0;
                    state_next = ST_WIPE;
                end
                else
                begin
                    state_next = ST_ITER_RD;
                end
            end
            ST_ITER_RD:
            begin
                addr_next = addr_reg + AW'(1);
                if (addr_reg == hi_reg)
                begin
                    state_next = ST_ITER_ACC;
                end
            end
            ST_ITER_ACC:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (dcnt_reg == 6'(SW - 1) && div_sel_reg)
                begin
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                addr_next = lo_reg;
                if (tn_calc == t_reg || it_reg == IW'(MAX_ITER - 1))
                begin
                    addr_next  = '0;
                    state_next = ST_WIPE;
                end
                else
                begin
                    state_next = ST_ITER_RD;
                end
            end
            ST_WIPE:
            begin
                addr_next = addr_reg + AW'(1);
                if (addr_reg == TOP)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        ram_raddr = addr_reg;
        case (state_reg)
            ST_CLEAR, ST_WIPE:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                ram_raddr = in_bin;
            end
            ST_RMW:
            begin
                ram_we    = 1'b1;
                ram_waddr = bin_reg;
                ram_wdata = (ram_rdata < CMAX) ? ram_rdata + CW'(1) : ram_rdata;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    logic [AW-1:0] rd_g_d;
    assign rd_g_d = addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            ov_v_reg  <= 1'b0;
            rd_v_reg  <= 1'b0;
            thr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            rd_v_reg  <= (state_reg == ST_SCAN) || (state_reg == ST_ITER_RD);
            if ((acc && in_op == OP_CLASSIFY) || (state_reg == ST_REPORT && out_free))
            begin
                ov_v_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_v_reg <= 1'b0;
            end
            if (state_reg == ST_REPORT && out_free)
            begin
                thr_reg <= t_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_g_reg <= rd_g_d;
        if (acc)
        begin
            bin_reg  <= in_bin;
            last_reg <= s_axis_tlast;
        end
        if (acc && in_op == OP_CLASSIFY)
        begin
            ov_data_reg <= {thr_reg, (in_pix < thr_reg) ? 8'd0 : WHITE_LEVEL};
            ov_user_reg <= 2'b00;
        end
        if (state_reg == ST_REPORT && out_free)
        begin
            ov_data_reg <= {t_reg, 8'd0};
            ov_user_reg <= {conv_reg, 1'b1};
        end
        if (state_reg == ST_RMW)
        begin
            found_reg <= 1'b0;
        end
        if (rd_v_reg && state_reg inside {ST_SCAN, ST_SCAN_END} && ram_rdata != '0)
        begin
            if (!found_reg)
            begin
                lo_reg <= rd_g_reg;
            end
            hi_reg    <= rd_g_reg;
            found_reg <= 1'b1;
        end
        if (state_reg == ST_SCAN_END)
        begin
            conv_reg <= 1'b1;
            it_reg   <= '0;
            if (!found_eff || lo_eff == hi_eff)
            begin
                t_reg <= 8'(lo_eff);
            end
            else
            begin
                t_reg <= 8'((9'(lo_eff) + 9'(hi_eff)) >> 1);
            end
        end
        if ((state_reg == ST_SCAN_END || state_reg == ST_DECIDE) && state_next == ST_ITER_RD)
        begin
            n1_reg <= '0;
            n2_reg <= '0;
            s1_reg <= '0;
            s2_reg <= '0;
        end
        if (rd_v_reg && state_reg inside {ST_ITER_RD, ST_ITER_ACC})
        begin
            if (8'(rd_g_reg) <= t_reg)
            begin
                n1_reg <= n1_reg + NW'(ram_rdata);
                s1_reg <= s1_reg + SW'(ram_rdata) * SW'(rd_g_reg);
            end
            else
            begin
                n2_reg <= n2_reg + NW'(ram_rdata);
                s2_reg <= s2_reg + SW'(ram_rdata) * SW'(rd_g_reg);
            end
        end
        if (state_reg == ST_ITER_ACC)
        begin
            div_sel_reg <= 1'b0;
            dq_reg      <= s1_reg;
            drem_reg    <= '0;
            dcnt_reg    <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            if (dcnt_reg == 6'(SW - 1) && !div_sel_reg)
            begin
                // first mean done: load the upper sum
                q1_reg      <= !dtrial[NW] ? {dq_reg[6:0], 1'b1} : {dq_reg[6:0], 1'b0};
                r1_reg      <= !dtrial[NW] ? dtrial[NW-1:0]
                               : {drem_reg[NW-2:0], dq_reg[SW-1]};
                div_sel_reg <= 1'b1;
                dq_reg      <= s2_reg;
                drem_reg    <= '0;
                dcnt_reg    <= '0;
            end
            else
            begin
                dcnt_reg <= dcnt_reg + 6'd1;
                if (!dtrial[NW])
                begin
                    drem_reg <= dtrial;
                    dq_reg   <= {dq_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= {drem_reg[NW-1:0], dq_reg[SW-1]};
                    dq_reg   <= {dq_reg[SW-2:0], 1'b0};
                end
                if (dcnt_reg == 6'(SW - 1))
                begin
                    q2_reg <= !dtrial[NW] ? {dq_reg[6:0], 1'b1} : {dq_reg[6:0], 1'b0};
                    r2_reg <= !dtrial[NW] ? dtrial[NW-1:0]
                              : {drem_reg[NW-2:0], dq_reg[SW-1]};
                end
            end
        end
        if (state_reg == ST_FRAC)
        begin
            pa_reg <= r1_reg * n2_reg;
            pb_reg <= (n2_reg - r2_reg) * n1_reg;
        end
        if (state_reg == ST_DECIDE)
        begin
            it_reg <= it_reg + IW'(1);
            conv_reg <= (tn_calc == t_reg);
            t_reg  <= tn_calc;
        end
    end

    assign m_axis_tvalid = ov_v_reg;
    assign m_axis_tdata  = ov_data_reg;
    assign m_axis_tuser  = ov_user_reg;

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input taken outside idle");
    a_report_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT && out_free) |=> (m_axis_tvalid && m_axis_tuser[0]))
        else $error("report lost");
    a_rmw_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && in_op == OP_ACCUM) |=> (state_reg == ST_RMW))
        else $error("histogram update skipped");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");

endmodule

// ----- hw/rtl/igt_ram.sv -----
module igt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
